[sv/shg_pkg.sv]
// shared types, constants and helper functions for the spatial hash grid core
// no dependencies
package shg_pkg;

	localparam int POOL_DEPTH    = 1024;
	localparam int CELL_DEPTH    = 5460;
	localparam int TOP_LEVEL     = 5;
	localparam int FRACTION_BITS = 8;
	localparam int GRID_LOG      = 6;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_MOVE   = 2'd1;
	localparam logic [1:0] CMD_RESIZE = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_FULL    = 2'd1;
	localparam logic [1:0] STS_INVALID = 2'd2;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_LOAD   = 4'd2;
	localparam logic [3:0] S_CHECK  = 4'd3;
	localparam logic [3:0] S_CALC   = 4'd4;
	localparam logic [3:0] S_DECIDE = 4'd5;
	localparam logic [3:0] S_OUT_A  = 4'd6;
	localparam logic [3:0] S_OUT_B  = 4'd7;
	localparam logic [3:0] S_HREAD  = 4'd8;
	localparam logic [3:0] S_IN_A   = 4'd9;
	localparam logic [3:0] S_IN_B   = 4'd10;
	localparam logic [3:0] S_FREE   = 4'd11;
	localparam logic [3:0] S_RESP   = 4'd12;

	typedef struct packed {
		logic [1:0]         command;
		logic [9:0]         entity;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [22:0]        radius;
		logic [31:0]        user_ref;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  entity_index;
		logic [2:0]  grid_level;
		logic [11:0] cell_index;
		logic [5:0]  occupied_levels;
	} rsp_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] level;
		logic [11:0] slot;
	} place_t;

	typedef struct packed {
		logic [3:0] step;
		logic       load;
	} ctl_t;

	typedef struct packed {
		logic       clr_done;
		logic [1:0] op;
		logic       chk_err;
		logic       relink;
		logic       rsp_free;
	} sts_t;

	function automatic logic [12:0] level_base(input logic [2:0] lvl);
		logic [12:0] b;
		case (lvl)
			3'd0: b = 13'd0;
			3'd1: b = 13'd4096;
			3'd2: b = 13'd5120;
			3'd3: b = 13'd5376;
			3'd4: b = 13'd5440;
			3'd5: b = 13'd5456;
			default: b = 13'd0;
		endcase
		return b;
	endfunction

	function automatic logic [5:0] fold_axis(input logic [23:0] raw, input logic [4:0] sh,
			input logic [2:0] slog);
		logic [23:0] mag;
		logic [23:0] c;
		logic [6:0]  side;
		logic [5:0]  m;
		logic [5:0]  low;
		mag  = raw[23] ? (24'd0 - raw) : raw;
		c    = mag >> sh;
		side = 7'd1 << slog;
		m    = 6'(side - 7'd1);
		low  = c[5:0] & m;
		if (|(c[6:0] & side))
			return m - low;
		return low;
	endfunction

	function automatic logic [11:0] cell_of(input logic [23:0] x, input logic [23:0] y,
			input logic [2:0] lvl, input logic [3:0] bcl);
		logic [4:0] sh;
		logic [2:0] slog;
		logic [5:0] cx;
		logic [5:0] cy;
		sh   = 5'(FRACTION_BITS) + 5'(bcl) + 5'(lvl);
		slog = 3'(GRID_LOG) - lvl;
		cx   = fold_axis(x, sh, slog);
		cy   = fold_axis(y, sh, slog);
		return 12'(cx) | (12'(cy) << slog);
	endfunction

	function automatic logic [2:0] choose_level(input logic [22:0] rad, input logic [3:0] bcl);
		logic [15:0] rounded;
		logic [4:0]  msb;
		logic [4:0]  lvl;
		rounded = rad[22:7];
		msb = 5'd0;
		if (17'(rounded) < (17'd1 << bcl))
			return 3'd0;
		for (int i = 0; i < 16; i++)
			if (rounded[i])
				msb = 5'(i);
		lvl = msb - 5'(bcl) + 5'd1;
		if (lvl > 5'(TOP_LEVEL))
			return 3'(TOP_LEVEL);
		return lvl[2:0];
	endfunction

endpackage

[sv/spatial_hash_grid_maintenance_core.sv]
// spatial hash grid maintenance core, top level
// one command at a time; the next command is taken only after the response of the
// previous one is registered, with the pace set by the dependent reads
// and writes of the entity and cell-head memories and by response stalls
// after reset, all 5460 cell-head entries are cleared before the first command is taken
// reset is asynchronous, active low; depends on shg_pkg, shg_ctrl, shg_dp
module spatial_hash_grid_maintenance_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  shg_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output shg_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [3:0]    cfg_data
);
	import shg_pkg::*;

	ctl_t ctl;
	sts_t sts;

	shg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.sts       (sts),
		.ctl       (ctl)
	);

	shg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item      (cmd),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

	assign cmd_stall = (ctl.step != S_IDLE);
	assign cfg_ready = 1'b1;

endmodule

[sv/shg_ctrl.sv]
// command sequencer for the spatial hash grid core
// depends on shg_pkg
module shg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  shg_pkg::sts_t sts,
	output shg_pkg::ctl_t ctl
);
	import shg_pkg::*;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (sts.clr_done) state_d = S_IDLE;
			S_IDLE:   if (cmd_valid) state_d = S_LOAD;
			S_LOAD:   state_d = S_CHECK;
			S_CHECK:  state_d = sts.chk_err ? S_RESP : S_CALC;
			S_CALC:   state_d = S_DECIDE;
			S_DECIDE: begin
				if (sts.op == CMD_INSERT)
					state_d = S_HREAD;
				else if (sts.op == CMD_REMOVE || sts.relink)
					state_d = S_OUT_A;
				else
					state_d = S_RESP;
			end
			S_OUT_A:  state_d = S_OUT_B;
			S_OUT_B:  state_d = (sts.op == CMD_REMOVE) ? S_FREE : S_HREAD;
			S_HREAD:  state_d = S_IN_A;
			S_IN_A:   state_d = S_IN_B;
			S_IN_B:   state_d = S_RESP;
			S_FREE:   state_d = S_RESP;
			S_RESP:   if (sts.rsp_free) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	assign ctl.step = state_q;
	assign ctl.load = (state_q == S_IDLE) && cmd_valid;

	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && !sts.clr_done) |=> state_q == S_CLEAR)
		else $error("clear pass left early");
	a_err_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && sts.chk_err) |=> state_q == S_RESP)
		else $error("failed command not answered");
	a_free_remove: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FREE |-> sts.op == CMD_REMOVE)
		else $error("free step outside remove");

endmodule

[sv/shg_dp.sv]
// datapath of the spatial hash grid core: memories, pool and level bookkeeping
// depends on shg_pkg
module shg_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  shg_pkg::ctl_t ctl,
	input  shg_pkg::cmd_t item,
	input  logic          cfg_valid,
	input  logic [3:0]    cfg_data,
	input  logic          rsp_stall,
	output shg_pkg::sts_t sts,
	output shg_pkg::rsp_t rsp,
	output logic          rsp_valid
);
	import shg_pkg::*;

	logic [9:0]  heads_mem [CELL_DEPTH];
	logic [9:0]  next_mem  [POOL_DEPTH];
	logic [9:0]  prev_mem  [POOL_DEPTH];
	place_t      place_mem [POOL_DEPTH];
	logic [23:0] posx_mem  [POOL_DEPTH];
	logic [23:0] posy_mem  [POOL_DEPTH];
	logic [22:0] rad_mem   [POOL_DEPTH];
	logic [31:0] uref_mem  [POOL_DEPTH];

	logic [3:0]  bcl_q;
	logic [12:0] clr_q;
	logic [9:0]  free_head_q;
	logic [10:0] pool_used_q;
	logic [10:0] counts_q [TOP_LEVEL+1];
	logic [5:0]  bitmap_q;

	logic [1:0]  op_q;
	logic [9:0]  ent_q;
	logic [23:0] px_q, py_q;
	logic [22:0] rad_q;
	logic [31:0] uref_q;

	logic [9:0]  idx_q, nx_q, pv_q;
	logic [2:0]  lvl_old_q, lvl_new_q, out_lvl_q;
	logic [11:0] cell_old_q, cell_new_q, out_cell_q;
	logic [23:0] cur_x_q, cur_y_q;
	logic [1:0]  status_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [9:0]  heads_rd_q, next_rd_q, prev_rd_q;
	place_t      place_rd_q;
	logic [23:0] posx_rd_q, posy_rd_q;

	logic [9:0]  rd_addr;
	logic [9:0]  next_addr;
	logic [12:0] h_new, h_old;
	logic        chk_full, chk_inv, rsp_free;
	logic [5:0]  occ_chk;

	assign rd_addr   = ent_q;
	assign next_addr = (op_q == CMD_INSERT) ? free_head_q : ent_q;
	assign h_new     = level_base(lvl_new_q) + 13'(cell_new_q);
	assign h_old     = level_base(lvl_old_q) + 13'(cell_old_q);
	assign chk_full  = (op_q == CMD_INSERT) && (free_head_q == 10'd0)
		&& (pool_used_q == 11'(POOL_DEPTH));
	assign chk_inv   = (op_q != CMD_INSERT) && ((ent_q == 10'd0) || !place_rd_q.valid);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// memory reads
	always_ff @(posedge clk) begin
		heads_rd_q <= heads_mem[h_new];
		next_rd_q  <= next_mem[next_addr];
		prev_rd_q  <= prev_mem[rd_addr];
		place_rd_q <= place_mem[rd_addr];
		posx_rd_q  <= posx_mem[rd_addr];
		posy_rd_q  <= posy_mem[rd_addr];
	end

	// memory writes
	always_ff @(posedge clk) begin
		case (ctl.step)
			S_CLEAR: begin
				heads_mem[clr_q] <= 10'd0;
				if (clr_q[12:10] == 3'd0)
					place_mem[clr_q[9:0]] <= '0;
			end
			S_CALC: begin
				if (op_q != CMD_RESIZE && op_q != CMD_REMOVE) begin
					posx_mem[idx_q] <= px_q;
					posy_mem[idx_q] <= py_q;
				end
				if (op_q == CMD_INSERT || op_q == CMD_RESIZE)
					rad_mem[idx_q] <= rad_q;
				if (op_q == CMD_INSERT)
					uref_mem[idx_q] <= uref_q;
			end
			S_OUT_A: begin
				if (pv_q == 10'd0)
					heads_mem[h_old] <= nx_q;
				else
					next_mem[pv_q] <= nx_q;
			end
			S_OUT_B: begin
				if (nx_q != 10'd0)
					prev_mem[nx_q] <= pv_q;
			end
			S_IN_A: begin
				heads_mem[h_new] <= idx_q;
				next_mem[idx_q]  <= heads_rd_q;
				place_mem[idx_q] <= '{valid: 1'b1, level: lvl_new_q, slot: cell_new_q};
				if (heads_rd_q != 10'd0)
					prev_mem[heads_rd_q] <= idx_q;
			end
			S_IN_B: prev_mem[idx_q] <= 10'd0;
			S_FREE: begin
				next_mem[idx_q]  <= free_head_q;
				place_mem[idx_q] <= '0;
			end
			default: ;
		endcase
	end

	// item and working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q   <= item.command;
			ent_q  <= item.entity;
			px_q   <= item.pos_x;
			py_q   <= item.pos_y;
			rad_q  <= item.radius;
			uref_q <= item.user_ref;
		end
		case (ctl.step)
			S_CHECK: begin
				nx_q       <= next_rd_q;
				pv_q       <= prev_rd_q;
				lvl_old_q  <= place_rd_q.level;
				cell_old_q <= place_rd_q.slot;
				out_lvl_q  <= place_rd_q.level;
				out_cell_q <= place_rd_q.slot;
				cur_x_q    <= (op_q == CMD_RESIZE) ? posx_rd_q : px_q;
				cur_y_q    <= (op_q == CMD_RESIZE) ? posy_rd_q : py_q;
				lvl_new_q  <= (op_q == CMD_MOVE) ? place_rd_q.level : choose_level(rad_q, bcl_q);
				status_q   <= chk_full ? STS_FULL : (chk_inv ? STS_INVALID : STS_OK);
			end
			S_CALC: cell_new_q <= cell_of(cur_x_q, cur_y_q, lvl_new_q, bcl_q);
			S_IN_A: begin
				out_lvl_q  <= lvl_new_q;
				out_cell_q <= cell_new_q;
			end
			default: ;
		endcase
	end

	// pool, levels and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcl_q       <= 4'd4;
			clr_q       <= '0;
			free_head_q <= '0;
			pool_used_q <= 11'd1;
			bitmap_q    <= '0;
			idx_q       <= '0;
			for (int i = 0; i <= TOP_LEVEL; i++)
				counts_q[i] <= '0;
		end else begin
			if (cfg_valid)
				bcl_q <= cfg_data;
			case (ctl.step)
				S_CLEAR: clr_q <= clr_q + 13'd1;
				S_CHECK: begin
					if (op_q != CMD_INSERT)
						idx_q <= ent_q;
					else if (free_head_q != 10'd0) begin
						idx_q       <= free_head_q;
						free_head_q <= next_rd_q;
					end else if (!chk_full) begin
						idx_q       <= pool_used_q[9:0];
						pool_used_q <= pool_used_q + 11'd1;
					end
				end
				S_OUT_B: begin
					if (counts_q[lvl_old_q] != 11'd0)
						counts_q[lvl_old_q] <= counts_q[lvl_old_q] - 11'd1;
					if (counts_q[lvl_old_q] <= 11'd1)
						bitmap_q[lvl_old_q] <= 1'b0;
				end
				S_IN_A: begin
					counts_q[lvl_new_q] <= counts_q[lvl_new_q] + 11'd1;
					bitmap_q[lvl_new_q] <= 1'b1;
				end
				S_FREE: free_head_q <= idx_q;
				default: ;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (ctl.step == S_RESP && rsp_free)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.step == S_RESP && rsp_free) begin
			rsp_q.status          <= status_q;
			rsp_q.entity_index    <= (status_q == STS_OK) ? idx_q : 10'd0;
			rsp_q.grid_level      <= (status_q == STS_OK) ? out_lvl_q : 3'd0;
			rsp_q.cell_index      <= (status_q == STS_OK) ? out_cell_q : 12'd0;
			rsp_q.occupied_levels <= bitmap_q;
		end
	end

	always_comb begin
		for (int i = 0; i <= TOP_LEVEL; i++)
			occ_chk[i] = (counts_q[i] != 11'd0);
	end

	assign sts.clr_done = (clr_q == 13'(CELL_DEPTH - 1));
	assign sts.op       = op_q;
	assign sts.chk_err  = chk_full || chk_inv;
	assign sts.relink   = (op_q == CMD_MOVE) ? (cell_new_q != cell_old_q)
		: (lvl_new_q != lvl_old_q);
	assign sts.rsp_free = rsp_free;
	assign rsp          = rsp_q;
	assign rsp_valid    = rsp_valid_q;

	a_bitmap: assert property (@(posedge clk) disable iff (!arst_n)
		bitmap_q == occ_chk)
		else $error("occupancy bitmap out of step with counts");
	a_pool: assert property (@(posedge clk) disable iff (!arst_n)
		pool_used_q <= 11'(POOL_DEPTH) && pool_used_q != 11'd0)
		else $error("pool fill out of range");
	a_free_push: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step == S_FREE |=> free_head_q == $past(idx_q))
		else $error("freed entity not on free list");
	a_link_in: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step == S_IN_A |=> bitmap_q[lvl_new_q])
		else $error("level empty after link in");

endmodule

[verif/spatial_hash_grid_maintenance_core_tb.sv]
// testbench for spatial_hash_grid_maintenance_core: directed and random grid commands,
// each response checked against a behavioral grid kept inside the testbench
// depends on shg_pkg and the core
`timescale 1ns / 100ps

module spatial_hash_grid_maintenance_core_tb;
	import shg_pkg::*;

	localparam int LIMIT = 1500000;
	localparam int LEVELS = TOP_LEVEL + 1;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [3:0] cfg_data;

	spatial_hash_grid_maintenance_core dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// grid mirror
	logic [9:0]  heads [CELL_DEPTH];
	logic [23:0] pos_x_mem [POOL_DEPTH];
	logic [23:0] pos_y_mem [POOL_DEPTH];
	logic [9:0]  next_mem [POOL_DEPTH];
	logic [9:0]  prev_mem [POOL_DEPTH];
	bit          alive [POOL_DEPTH];
	logic [2:0]  lvl_mem [POOL_DEPTH];
	logic [11:0] cell_mem [POOL_DEPTH];
	int          lvl_count [LEVELS];
	logic [5:0]  occupancy;
	logic [9:0]  free_top;
	int          pool_fill;
	logic [3:0]  base_log;

	rsp_t pending_rsp[$];
	int   errors;
	int   cycles;
	int   snd_pct;
	int   rcv_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int slot_base(int l);
		int b;
		b = 0;
		for (int k = 0; k < l; k++)
			b += (64 >> k) * (64 >> k);
		return b;
	endfunction

	function automatic int mirror_axis(logic [23:0] raw, int l);
		int mag;
		int c;
		int s;
		mag = raw[23] ? (32'h1000000 - int'(raw)) : int'(raw);
		c = mag >> (FRACTION_BITS + base_log + l);
		s = 64 >> l;
		if (c & s)
			return (s - 1) - (c & (s - 1));
		return c & (s - 1);
	endfunction

	function automatic int cell_at(int i, int l);
		return mirror_axis(pos_x_mem[i], l) | (mirror_axis(pos_y_mem[i], l) << (GRID_LOG - l));
	endfunction

	function automatic int level_for(logic [22:0] r);
		int rounded;
		int msb;
		int l;
		rounded = int'(r) >> 7;
		if (rounded < (1 << base_log))
			return 0;
		msb = 0;
		for (int k = 0; k < 16; k++)
			if (rounded[k])
				msb = k;
		l = msb - base_log + 1;
		return (l > TOP_LEVEL) ? TOP_LEVEL : l;
	endfunction

	function automatic void chain_add(int i);
		int l;
		int h;
		l = lvl_mem[i];
		cell_mem[i] = 12'(cell_at(i, l));
		h = slot_base(l) + cell_mem[i];
		next_mem[i] = heads[h];
		if (heads[h] != 0)
			prev_mem[heads[h]] = 10'(i);
		prev_mem[i] = '0;
		heads[h] = 10'(i);
		if (lvl_count[l] == 0)
			occupancy[l] = 1'b1;
		lvl_count[l]++;
	endfunction

	function automatic void chain_drop(int i);
		int l;
		l = lvl_mem[i];
		if (prev_mem[i] == 0)
			heads[slot_base(l) + cell_mem[i]] = next_mem[i];
		else
			next_mem[prev_mem[i]] = next_mem[i];
		if (next_mem[i] != 0)
			prev_mem[next_mem[i]] = prev_mem[i];
		if (lvl_count[l] != 0)
			lvl_count[l]--;
		if (lvl_count[l] == 0)
			occupancy[l] = 1'b0;
	endfunction

	function automatic rsp_t grid_update(cmd_t c);
		rsp_t r;
		int i;
		int nl;
		r = '0;
		i = 0;
		r.status = STS_OK;
		if (c.command == CMD_INSERT) begin
			if (free_top != 0) begin
				i = free_top;
				free_top = next_mem[i];
			end else if (pool_fill < POOL_DEPTH) begin
				i = pool_fill;
				pool_fill++;
			end else
				r.status = STS_FULL;
			if (r.status == STS_OK) begin
				pos_x_mem[i] = c.pos_x;
				pos_y_mem[i] = c.pos_y;
				lvl_mem[i] = 3'(level_for(c.radius));
				alive[i] = 1'b1;
				chain_add(i);
			end
		end else if (c.entity == 0 || !alive[c.entity]) begin
			r.status = STS_INVALID;
		end else begin
			i = c.entity;
			case (c.command)
				CMD_MOVE: begin
					pos_x_mem[i] = c.pos_x;
					pos_y_mem[i] = c.pos_y;
					if (cell_at(i, lvl_mem[i]) != cell_mem[i]) begin
						chain_drop(i);
						chain_add(i);
					end
				end
				CMD_RESIZE: begin
					nl = level_for(c.radius);
					if (nl != lvl_mem[i]) begin
						chain_drop(i);
						lvl_mem[i] = 3'(nl);
						chain_add(i);
					end
				end
				default: begin
					chain_drop(i);
					alive[i] = 1'b0;
					next_mem[i] = free_top;
					free_top = 10'(i);
				end
			endcase
		end
		if (r.status == STS_OK) begin
			r.entity_index = 10'(i);
			r.grid_level = lvl_mem[i];
			r.cell_index = cell_mem[i];
		end
		r.occupied_levels = occupancy;
		return r;
	endfunction

	task automatic report_err(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic send_cmd(cmd_t c);
		if ($urandom_range(99) < snd_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (cmd_stall);
		pending_rsp.push_back(grid_update(c));
	endtask

	task automatic settle;
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_base_log(logic [3:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		base_log = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int some_live();
		int k;
		for (int t = 0; t < 24; t++) begin
			k = $urandom_range(1, POOL_DEPTH - 1);
			if (alive[k])
				return k;
		end
		for (k = 1; k < POOL_DEPTH; k++)
			if (alive[k])
				return k;
		return 0;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick;
		c.command = CMD_INSERT;
		c.entity = 10'($urandom);
		c.pos_x = 24'($urandom);
		c.pos_y = 24'($urandom);
		if ($urandom_range(1)) begin
			c.pos_x = $signed(c.pos_x) >>> $urandom_range(0, 20);
			c.pos_y = $signed(c.pos_y) >>> $urandom_range(0, 20);
		end
		c.radius = 23'($urandom);
		c.radius = c.radius >> $urandom_range(0, 22);
		c.user_ref = $urandom;
		pick = $urandom_range(99);
		if (pick < 30)
			c.command = CMD_INSERT;
		else if (pick < 60)
			c.command = CMD_MOVE;
		else if (pick < 80)
			c.command = CMD_RESIZE;
		else
			c.command = CMD_REMOVE;
		if (c.command != CMD_INSERT && pick % 20 != 0)
			c.entity = 10'(some_live());
		return c;
	endfunction

	function automatic cmd_t make_cmd(logic [1:0] op, int e, int x, int y, int r);
		cmd_t c;
		c.command = op;
		c.entity = 10'(e);
		c.pos_x = 24'(x);
		c.pos_y = 24'(y);
		c.radius = 23'(r);
		c.user_ref = $urandom;
		return c;
	endfunction

	task automatic test_directed;
		write_base_log(4'd0);
		send_cmd(make_cmd(CMD_MOVE, 0, 0, 0, 0));
		send_cmd(make_cmd(CMD_REMOVE, 1023, 0, 0, 0));
		send_cmd(make_cmd(CMD_INSERT, 1023, 0, 0, 0));
		send_cmd(make_cmd(CMD_INSERT, 0, -8388608, 8388607, 23'h7fffff));
		send_cmd(make_cmd(CMD_INSERT, 0, 8388607, -8388608, 200));
		send_cmd(make_cmd(CMD_INSERT, 0, -256, 256, 128));
		send_cmd(make_cmd(CMD_MOVE, 1, 1, 1, 0));
		send_cmd(make_cmd(CMD_MOVE, 1, 40000, -90000, 0));
		send_cmd(make_cmd(CMD_MOVE, 2, 8388607, -8388608, 0));
		send_cmd(make_cmd(CMD_RESIZE, 3, 0, 0, 129));
		send_cmd(make_cmd(CMD_RESIZE, 3, 0, 0, 23'h7fffff));
		send_cmd(make_cmd(CMD_RESIZE, 2, 0, 0, 0));
		send_cmd(make_cmd(CMD_REMOVE, 1, 0, 0, 0));
		send_cmd(make_cmd(CMD_REMOVE, 1, 0, 0, 0));
		send_cmd(make_cmd(CMD_MOVE, 1, 5, 5, 0));
		send_cmd(make_cmd(CMD_INSERT, 0, 1000, 1000, 4096));
		send_cmd(make_cmd(CMD_REMOVE, 2, 0, 0, 0));
		send_cmd(make_cmd(CMD_REMOVE, 3, 0, 0, 0));
		send_cmd(make_cmd(CMD_REMOVE, 1, 0, 0, 0));
	endtask

	task automatic test_random(int n, logic [3:0] log_val);
		write_base_log(log_val);
		for (int k = 0; k < n; k++)
			send_cmd(rand_cmd());
	endtask

	task automatic test_pool_full;
		write_base_log(4'd15);
		while (free_top != 0 || pool_fill < POOL_DEPTH)
			send_cmd(make_cmd(CMD_INSERT, 0, $urandom, $urandom, $urandom));
		repeat (3) send_cmd(make_cmd(CMD_INSERT, 0, $urandom, $urandom, $urandom));
		repeat (40) send_cmd(make_cmd(CMD_REMOVE, some_live(), 0, 0, 0));
		send_cmd(make_cmd(CMD_REMOVE, 1023, 0, 0, 0));
	endtask

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_pct);
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[spatial_hash_grid_maintenance_core] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0)
				report_err("unexpected response transaction");
			else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_err($sformatf("status %0d want %0d", rsp.status, want.status));
				if (rsp.entity_index !== want.entity_index)
					report_err($sformatf("entity_index %0d want %0d",
						rsp.entity_index, want.entity_index));
				if (rsp.grid_level !== want.grid_level)
					report_err($sformatf("grid_level %0d want %0d",
						rsp.grid_level, want.grid_level));
				if (rsp.cell_index !== want.cell_index)
					report_err($sformatf("cell_index %0d want %0d",
						rsp.cell_index, want.cell_index));
				if (rsp.occupied_levels !== want.occupied_levels)
					report_err($sformatf("occupied_levels %h want %h",
						rsp.occupied_levels, want.occupied_levels));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		rsp_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		cycles = 0;
		errors = 0;
		snd_pct = 14;
		rcv_pct = 50;
		for (int k = 0; k < CELL_DEPTH; k++)
			heads[k] = '0;
		for (int k = 0; k < POOL_DEPTH; k++)
			alive[k] = 1'b0;
		for (int k = 0; k < LEVELS; k++)
			lvl_count[k] = 0;
		occupancy = '0;
		free_top = '0;
		pool_fill = 1;
		base_log = 4'd4;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(160, 4'd4);
		snd_pct = 50;
		rcv_pct = 14;
		test_random(160, 4'($urandom_range(0, 15)));
		test_pool_full();
		snd_pct = 0;
		rcv_pct = 0;
		test_random(100, 4'd2);
		settle();
		if (errors == 0)
			$display("[spatial_hash_grid_maintenance_core] OK");
		else
			$display("[spatial_hash_grid_maintenance_core] ERROR");
		$finish;
	end

endmodule

[sim.f]
sv/shg_pkg.sv
sv/shg_ctrl.sv
sv/shg_dp.sv
sv/spatial_hash_grid_maintenance_core.sv
verif/spatial_hash_grid_maintenance_core_tb.sv
